// ===== rtl/core/coes_pkg.sv =====
// ----------------------------------------------------------------------------
// coes_pkg
// Shared types and constants of the coupled oscillator / body Euler step unit:
// item payloads, configuration layout, register indexes and datapath commands.
// ----------------------------------------------------------------------------
package coes_pkg;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int DT_W        = 31;
    localparam int CFG_INDEX_W = 3;
    // at most two oscillators, so one index bit
    localparam int OSC_IDX_W   = 1;

    // configuration reset values (Q16.16)
    localparam logic [DT_W-1:0]          RST_TIME_STEP   = 31'd6554;
    localparam logic signed [DATA_W-1:0] RST_FREQ_FIRST  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_FREQ_SECOND = 32'sd131072;
    localparam logic signed [DATA_W-1:0] RST_INIT_X      = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_INIT_Y      = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_INIT_Z      = 32'sd32768;

    // register indexes of the write port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_STEP   = 3'd0,
        REG_FREQ_FIRST  = 3'd1,
        REG_FREQ_SECOND = 3'd2,
        REG_INIT_X      = 3'd3,
        REG_INIT_Y      = 3'd4,
        REG_INIT_Z      = 3'd5
    } reg_idx_t;

    // input and result beats
    typedef struct packed {
        logic advance;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic                     saturated;
    } out_item_t;

    // configuration register contents
    typedef struct packed {
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] freq_first;
        logic signed [DATA_W-1:0] freq_second;
        logic signed [DATA_W-1:0] init_accel_x;
        logic signed [DATA_W-1:0] init_accel_y;
        logic signed [DATA_W-1:0] init_accel_z;
    } cfg_t;

    // multiplier operations; the same code selects the write-back in the next cycle
    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_F2     = 3'd1,
        MUL_DAMP   = 3'd2,
        MUL_SPRING = 3'd3,
        MUL_POS    = 3'd4,
        MUL_SPD    = 3'd5,
        MUL_VEL    = 3'd6
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic                 clear_item;
        logic                 start_step;
        mul_op_t              mul_op;
        logic                 calc_acc;
        logic                 add_moment;
        logic                 calc_moment;
        logic                 load_out;
        logic [OSC_IDX_W-1:0] osc_idx;
    } cmd_t;

endpackage

// ===== rtl/core/coes_stream_if.sv =====
// ----------------------------------------------------------------------------
// coes_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface coes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/coes_ctrl.sv =====
// ----------------------------------------------------------------------------
// coes_ctrl
// Step sequencer: handles both handshakes and walks the datapath through the
// oscillator updates, the body update and the result load.
// ----------------------------------------------------------------------------
module coes_ctrl #(
    parameter int OSCILLATOR_COUNT = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_advance,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output coes_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_F2,
        ST_DAMP,
        ST_SPRING,
        ST_POSM,
        ST_ACC,
        ST_SPDM,
        ST_SPDW,
        ST_MOMENT,
        ST_VELM,
        ST_VELW,
        ST_DONE
    } state_t;

    localparam logic [coes_pkg::OSC_IDX_W-1:0] OSC_LAST =
        coes_pkg::OSC_IDX_W'(OSCILLATOR_COUNT - 1);

    state_t                            state_reg;
    logic                              in_ready_reg;
    logic                              out_valid_reg;
    logic [coes_pkg::OSC_IDX_W-1:0]    osc_idx_reg;
    logic                              in_beat;
    logic                              out_free;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign in_beat   = in_valid && in_ready_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // state, handshake flags and oscillator index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            osc_idx_reg   <= '0;
        end
        else
        begin
            // result taken, unless a new one is loaded in the same cycle
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        in_ready_reg <= 1'b0;
                        osc_idx_reg  <= '0;
                        state_reg    <= in_advance ? ST_PREP : ST_DONE;
                    end
                end
                ST_PREP:   state_reg <= ST_F2;
                ST_F2:     state_reg <= ST_DAMP;
                ST_DAMP:   state_reg <= ST_SPRING;
                ST_SPRING: state_reg <= ST_POSM;
                ST_POSM:   state_reg <= ST_ACC;
                ST_ACC:    state_reg <= ST_SPDM;
                ST_SPDM:   state_reg <= ST_SPDW;
                ST_SPDW:
                begin
                    if (osc_idx_reg == OSC_LAST)
                    begin
                        state_reg <= ST_MOMENT;
                    end
                    else
                    begin
                        osc_idx_reg <= osc_idx_reg + 1'b1;
                        state_reg   <= ST_F2;
                    end
                end
                ST_MOMENT: state_reg <= ST_VELM;
                ST_VELM:   state_reg <= ST_VELW;
                ST_VELW:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        in_ready_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // datapath commands per state
    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = coes_pkg::MUL_NONE;
        cmd.osc_idx    = osc_idx_reg;
        case (state_reg)
            ST_IDLE:   cmd.clear_item  = in_beat;
            ST_PREP:   cmd.start_step  = 1'b1;
            ST_F2:     cmd.mul_op      = coes_pkg::MUL_F2;
            ST_DAMP:   cmd.mul_op      = coes_pkg::MUL_DAMP;
            ST_SPRING: cmd.mul_op      = coes_pkg::MUL_SPRING;
            ST_POSM:   cmd.mul_op      = coes_pkg::MUL_POS;
            ST_ACC:    cmd.calc_acc    = 1'b1;
            ST_SPDM:
            begin
                cmd.mul_op     = coes_pkg::MUL_SPD;
                cmd.add_moment = 1'b1;
            end
            ST_MOMENT: cmd.calc_moment = 1'b1;
            ST_VELM:   cmd.mul_op      = coes_pkg::MUL_VEL;
            ST_DONE:   cmd.load_out    = out_free;
            default:   cmd.mul_op      = coes_pkg::MUL_NONE;
        endcase
    end

endmodule

// ===== rtl/core/coes_datapath.sv =====
// ----------------------------------------------------------------------------
// coes_datapath
// Shared signed 32x32 multiplier with round-half-up and saturation, oscillator
// and body state, and the saturating adders of the Euler update.
// ----------------------------------------------------------------------------
module coes_datapath #(
    parameter int FRACTION_BITS    = 16,
    parameter int OSCILLATOR_COUNT = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  coes_pkg::cmd_t     cmd,
    input  coes_pkg::cfg_t     cfg,
    output coes_pkg::out_item_t out_item
);

    localparam int DW      = coes_pkg::DATA_W;
    localparam int CLAMP_W = 66;

    localparam logic signed [DW-1:0] ONE_FX = DW'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [DW-1:0] DISSIP_FX =
        DW'(((64'sd1 <<< (FRACTION_BITS + 1)) + 64'sd2) / 64'sd5);
    localparam logic signed [64:0] HALF_FX = 65'sd1 <<< (FRACTION_BITS - 1);
    localparam logic signed [CLAMP_W-1:0] FX_MAX = CLAMP_W'(64'sd2147483647);
    localparam logic signed [CLAMP_W-1:0] FX_MIN = -FX_MAX - CLAMP_W'(64'sd1);

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 sat;
    } sat_t;

    // saturate a wide signed value to 32 bits, flagging overflow
    function automatic sat_t clamp32(input logic signed [CLAMP_W-1:0] v);
        sat_t r;
        if (v > FX_MAX)
        begin
            r.value = DW'(FX_MAX);
            r.sat   = 1'b1;
        end
        else if (v < FX_MIN)
        begin
            r.value = DW'(FX_MIN);
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = DW'(v);
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    // state
    logic signed [DW-1:0]  pos_reg   [OSCILLATOR_COUNT];
    logic signed [DW-1:0]  speed_reg [OSCILLATOR_COUNT];
    logic signed [DW-1:0]  vel_reg   [3];
    logic signed [DW-1:0]  body_accel_reg;
    logic                  first_step_reg;
    logic                  sat_reg;

    // working registers
    logic signed [63:0]    prod_reg;
    coes_pkg::mul_op_t     prod_op_reg;
    logic signed [DW-1:0]  f2_reg;
    logic signed [DW-1:0]  damp_reg;
    logic signed [DW-1:0]  spring_reg;
    logic signed [DW-1:0]  acc_reg;
    logic signed [DW-1:0]  moment_reg;
    logic signed [33:0]    coupling_reg;
    logic signed [33:0]    moment_sum_reg;
    coes_pkg::out_item_t   out_reg;

    // combinational
    logic signed [DW-1:0]  freq_sel;
    logic signed [DW-1:0]  pos_sel;
    logic signed [DW-1:0]  speed_sel;
    logic signed [DW-1:0]  dt_s;
    logic signed [DW-1:0]  op_a;
    logic signed [DW-1:0]  op_b;
    logic signed [64:0]    rnd_wide;
    logic signed [64:0]    rnd_shift;
    sat_t                  rnd;
    sat_t                  pos_upd;
    sat_t                  speed_upd;
    sat_t                  vel_upd;
    sat_t                  acc_upd;
    sat_t                  moment_upd;
    logic signed [35:0]    acc_full;
    logic signed [33:0]    coupling_next;
    logic                  sat_now;

    assign out_item = out_reg;
    assign dt_s     = DW'($signed({1'b0, cfg.time_step}));
    assign freq_sel = (cmd.osc_idx == '0) ? cfg.freq_first : cfg.freq_second;

    // oscillator state of the current index
    always_comb
    begin
        pos_sel   = pos_reg[0];
        speed_sel = speed_reg[0];
        for (int k = 0; k < OSCILLATOR_COUNT; k++)
        begin
            if (cmd.osc_idx == coes_pkg::OSC_IDX_W'(k))
            begin
                pos_sel   = pos_reg[k];
                speed_sel = speed_reg[k];
            end
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (cmd.mul_op)
            coes_pkg::MUL_F2:
            begin
                op_a = freq_sel;
                op_b = freq_sel;
            end
            coes_pkg::MUL_DAMP:
            begin
                op_a = DISSIP_FX;
                op_b = speed_sel;
            end
            coes_pkg::MUL_SPRING:
            begin
                op_a = f2_reg;
                op_b = pos_sel;
            end
            coes_pkg::MUL_POS:
            begin
                op_a = speed_sel;
                op_b = dt_s;
            end
            coes_pkg::MUL_SPD:
            begin
                op_a = acc_reg;
                op_b = dt_s;
            end
            coes_pkg::MUL_VEL:
            begin
                op_a = moment_reg;
                op_b = dt_s;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // round half up, floor shift, saturate
    assign rnd_wide  = 65'(prod_reg) + HALF_FX;
    assign rnd_shift = rnd_wide >>> FRACTION_BITS;
    assign rnd       = clamp32(CLAMP_W'(rnd_shift));

    // saturating adders of the update
    assign pos_upd    = clamp32(CLAMP_W'(pos_sel) + CLAMP_W'(rnd.value));
    assign speed_upd  = clamp32(CLAMP_W'(speed_sel) + CLAMP_W'(rnd.value));
    assign vel_upd    = clamp32(CLAMP_W'(vel_reg[0]) + CLAMP_W'(rnd.value));
    assign acc_full   = 36'(coupling_reg) - 36'(damp_reg) - 36'(spring_reg);
    assign acc_upd    = clamp32(CLAMP_W'(acc_full));
    assign moment_upd = clamp32(CLAMP_W'(moment_sum_reg));

    // coupling of all axes, weighted one: previous or initial body acceleration
    always_comb
    begin
        if (first_step_reg)
        begin
            coupling_next = 34'(cfg.init_accel_x) + 34'(cfg.init_accel_y)
                          + 34'(cfg.init_accel_z);
        end
        else
        begin
            coupling_next = 34'(body_accel_reg) + 34'(body_accel_reg)
                          + 34'(body_accel_reg);
        end
    end

    // overflow seen this cycle
    always_comb
    begin
        case (prod_op_reg)
            coes_pkg::MUL_F2,
            coes_pkg::MUL_DAMP,
            coes_pkg::MUL_SPRING: sat_now = rnd.sat;
            coes_pkg::MUL_POS:    sat_now = rnd.sat | pos_upd.sat;
            coes_pkg::MUL_SPD:    sat_now = rnd.sat | speed_upd.sat;
            coes_pkg::MUL_VEL:    sat_now = rnd.sat | vel_upd.sat;
            default:              sat_now = 1'b0;
        endcase
        if (cmd.calc_acc && acc_upd.sat)
        begin
            sat_now = 1'b1;
        end
        if (cmd.calc_moment && moment_upd.sat)
        begin
            sat_now = 1'b1;
        end
    end

    // multiplier pipeline register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_op_reg <= coes_pkg::MUL_NONE;
        end
        else
        begin
            prod_op_reg <= cmd.mul_op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    // intermediate results
    always_ff @(posedge clk)
    begin
        if (prod_op_reg == coes_pkg::MUL_F2)
        begin
            f2_reg <= rnd.value;
        end
        if (prod_op_reg == coes_pkg::MUL_DAMP)
        begin
            damp_reg <= rnd.value;
        end
        if (prod_op_reg == coes_pkg::MUL_SPRING)
        begin
            spring_reg <= rnd.value;
        end
        if (cmd.calc_acc)
        begin
            acc_reg <= acc_upd.value;
        end
        if (cmd.calc_moment)
        begin
            moment_reg <= moment_upd.value;
        end
        if (cmd.start_step)
        begin
            coupling_reg <= coupling_next;
        end
        if (cmd.clear_item)
        begin
            moment_sum_reg <= '0;
        end
        else if (cmd.add_moment)
        begin
            moment_sum_reg <= moment_sum_reg - 34'(acc_reg);
        end
    end

    // oscillator position and speed
    for (genvar k = 0; k < OSCILLATOR_COUNT; k++)
    begin : g_osc
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg[k]   <= ONE_FX;
                speed_reg[k] <= '0;
            end
            else if (cmd.osc_idx == coes_pkg::OSC_IDX_W'(k))
            begin
                if (prod_op_reg == coes_pkg::MUL_POS)
                begin
                    pos_reg[k] <= pos_upd.value;
                end
                if (prod_op_reg == coes_pkg::MUL_SPD)
                begin
                    speed_reg[k] <= speed_upd.value;
                end
            end
        end
    end

    // body state, first step mark and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_accel_reg <= '0;
            first_step_reg <= 1'b1;
            sat_reg        <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.start_step)
            begin
                first_step_reg <= 1'b0;
            end
            if (cmd.calc_moment)
            begin
                body_accel_reg <= moment_upd.value;
            end
            // all three axes start equal and share one acceleration, so one sum serves
            if (prod_op_reg == coes_pkg::MUL_VEL)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= vel_upd.value;
                end
            end
            if (cmd.clear_item)
            begin
                sat_reg <= 1'b0;
            end
            else if (sat_now)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.vel_x     <= vel_reg[0];
            out_reg.vel_y     <= vel_reg[1];
            out_reg.vel_z     <= vel_reg[2];
            out_reg.saturated <= sat_reg;
        end
    end

endmodule

// ===== rtl/core/coupled_oscillator_body_euler_step_unit.sv =====
// ----------------------------------------------------------------------------
// coupled_oscillator_body_euler_step_unit
// One explicit Euler step of a rigid body's angular motion coupled to damped
// oscillators per advancing beat; reports the body velocity for every beat.
//
//   channel   dir   payload                               handshake
//   in_ch     in    advance                               valid / ready
//   out_ch    out   vel_x, vel_y, vel_z, saturated        valid / ready
//   cfg       in    cfg_index, cfg_data                   cfg_write_en
//
// An advancing beat is paced from acceptance to the result register by the
// single shared multiplier, which serves all 5 * OSCILLATOR_COUNT + 1 products
// in turn. A reporting-only beat goes straight to the result load.
// One beat is in work at a time. The result register lets a new beat be
// taken while a result waits; a stalled result holds the sequencer in its
// final state. Reset is immediate.
// ----------------------------------------------------------------------------
module coupled_oscillator_body_euler_step_unit #(
    parameter int FRACTION_BITS    = 16,
    parameter int OSCILLATOR_COUNT = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    coes_stream_if.sink                         in_ch,
    coes_stream_if.source                       out_ch,
    input  logic                                cfg_write_en,
    input  logic [coes_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [coes_pkg::DATA_W-1:0]         cfg_data
);

    coes_pkg::cfg_t      cfg_reg;
    coes_pkg::cmd_t      cmd;
    coes_pkg::out_item_t out_item;
    coes_pkg::in_item_t  in_item;
    logic                in_ready;
    logic                out_valid;

    assign in_item        = in_ch.payload;
    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid;
    assign out_ch.payload = out_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step    <= coes_pkg::RST_TIME_STEP;
            cfg_reg.freq_first   <= coes_pkg::RST_FREQ_FIRST;
            cfg_reg.freq_second  <= coes_pkg::RST_FREQ_SECOND;
            cfg_reg.init_accel_x <= coes_pkg::RST_INIT_X;
            cfg_reg.init_accel_y <= coes_pkg::RST_INIT_Y;
            cfg_reg.init_accel_z <= coes_pkg::RST_INIT_Z;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                coes_pkg::REG_TIME_STEP:
                    cfg_reg.time_step <= cfg_data[coes_pkg::DT_W-1:0];
                coes_pkg::REG_FREQ_FIRST:  cfg_reg.freq_first   <= cfg_data;
                coes_pkg::REG_FREQ_SECOND: cfg_reg.freq_second  <= cfg_data;
                coes_pkg::REG_INIT_X:      cfg_reg.init_accel_x <= cfg_data;
                coes_pkg::REG_INIT_Y:      cfg_reg.init_accel_y <= cfg_data;
                coes_pkg::REG_INIT_Z:      cfg_reg.init_accel_z <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sequencer
    coes_ctrl #(
        .OSCILLATOR_COUNT (OSCILLATOR_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_advance (in_item.advance),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd)
    );

    // arithmetic and state
    coes_datapath #(
        .FRACTION_BITS    (FRACTION_BITS),
        .OSCILLATOR_COUNT (OSCILLATOR_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .out_item (out_item)
    );

    // one beat in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken while a beat is still in work");

    // a reporting-only beat passes through the final state to an empty result register
    a_report_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && !in_item.advance && !out_ch.valid
        |-> ##2 out_ch.valid)
        else $error("reporting beat result late");

    // all axes share one acceleration, so their velocities never part
    a_axes_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_item.vel_x == out_item.vel_y)
                      && (out_item.vel_y == out_item.vel_z))
        else $error("body velocity axes differ");

endmodule
